// ----- rtl/smoothstep_fade_engine_macros.svh -----
// Assertion macros shared by the fade engine checker.
// Needs a clock named clk and an active-high reset named rst in the using scope.
`ifndef SMOOTHSTEP_FADE_ENGINE_MACROS_SVH
`define SMOOTHSTEP_FADE_ENGINE_MACROS_SVH

// Same-cycle implication.
`define SFE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fade engine assertion failed");

// Next-cycle implication.
`define SFE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fade engine assertion failed");

`endif

// ----- rtl/sfe_pkg.sv -----
// Shared types and constants of the smoothstep fade engine.
// No dependencies; imported by the engine, its serial divider and its checker.
`timescale 1ns / 1ps

package sfe_pkg;

  // command codes
  localparam int CMD_W = 2;
  typedef logic [CMD_W-1:0] cmd_t;
  localparam cmd_t CMD_TICK = 2'd0;
  localparam cmd_t CMD_FADE = 2'd1;
  localparam cmd_t CMD_HIDE = 2'd2;

  // stream payload
  localparam int IN_DATA_W   = 24;  // show, fade_ms, zero pad
  localparam int OUT_DATA_W  = 24;  // level, flags, zero pad
  localparam int OUT_LEVEL_W = 16;
  localparam int FADE_W      = 16;
  localparam int DUR_W       = 15;  // non-negative part of fade_ms

  // epsilon register
  localparam int EPS_W = 16;
  typedef logic [EPS_W-1:0] eps_t;
  localparam eps_t EPS_RESET = 16'd66;

  // easing arithmetic
  localparam int FRAC_BITS = 16;                      // t and s are Q0.16
  localparam int DIV_CNT_W = $clog2(FRAC_BITS + 1);
  localparam int MUL_A_W   = 32;
  localparam int MUL_B_W   = 18;
  localparam logic [MUL_B_W-1:0] S_COEF = 18'h30000;  // 3.0 in Q2.16

endpackage

// ----- rtl/sfe_div.sv -----
// Restoring divider, one quotient bit per cycle: quo = floor(num * 2^16 / den).
// Requires num < den. Uses sfe_pkg.
`timescale 1ns / 1ps

module sfe_div import sfe_pkg::*; #(
  parameter int TIME_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [TIME_BITS-1:0] num,
  input  logic [TIME_BITS-1:0] den,
  output logic [FRAC_BITS-1:0] quo,
  output logic                 done
);

  logic [TIME_BITS-1:0] rem;
  logic [TIME_BITS-1:0] dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic [TIME_BITS:0]   rem2;
  logic [TIME_BITS:0]   diff;
  logic                 ge;

  assign rem2 = {rem, 1'b0};
  assign diff = rem2 - {1'b0, dvs};
  assign ge   = (rem2 >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= DIV_CNT_W'(FRAC_BITS);
      end else if (cnt != '0) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // remainder stays below den, so it fits TIME_BITS
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dvs <= den;
    end else if (cnt != '0) begin
      rem <= ge ? diff[TIME_BITS-1:0] : rem2[TIME_BITS-1:0];
      quo <= {quo[FRAC_BITS-2:0], ge};
    end
  end

endmodule

// ----- rtl/sfe_mul.sv -----
// Shift-add multiplier, one multiplier bit per cycle.
// Standalone; prod holds the full A_W + B_W bit product once done pulses.
`timescale 1ns / 1ps

module sfe_mul #(
  parameter int A_W = 32,
  parameter int B_W = 18
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] prod,
  output logic               done
);

  localparam int CNT_W = $clog2(B_W + 1);

  logic [A_W-1:0]   hi;
  logic [A_W-1:0]   mcand;
  logic [B_W-1:0]   lo;     // multiplier bits out, product bits in
  logic [CNT_W-1:0] cnt;
  logic [A_W:0]     sum;

  assign sum  = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : '0);
  assign prod = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(B_W);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hi    <= '0;
      lo    <= b;
      mcand <= a;
    end else if (cnt != '0) begin
      hi <= sum[A_W:1];
      lo <= {sum[0], lo[B_W-1:1]};
    end
  end

endmodule

// ----- rtl/smoothstep_fade_engine.sv -----
// Smoothstep fade engine. Items arrive on the s_t* stream: s_tuser carries the
// command (tick, fade, hide) and s_tdata the show flag and the signed fade
// duration in ms. Every item yields exactly one result on the m_t* stream with
// the level (Q0.16 style, all ones is full), the running and renderable flags
// and the target visibility. One item is worked on at a time. A tick that
// moves a running fade along the curve raises m_tvalid after a check of elapsed
// against the duration (the elapsed count advances at the accepting edge), the
// bit-serial divider for t = elapsed/duration, three passes through the shared
// shift-add multiplier (t*t, t^2*(3-2t), gap*s), a handoff after each of those
// four units, and the load of the result, which waits while the output register
// holds an untaken result. A tick that reaches the end of the fade passes the
// check, then the result load; every other item (idle tick, fade, hide, unused
// code) goes straight to the result load. The result sits in an output
// register, so the next item can be taken in the cycle after its result is
// loaded, even if the result waits. epsilon_level is written through
// cfg_valid/cfg_data, always ready; the user writes it only while idle, which
// the block does not enforce. Uses sfe_pkg, sfe_div and sfe_mul.
`timescale 1ns / 1ps

module smoothstep_fade_engine import sfe_pkg::*; #(
  parameter int LEVEL_BITS = 16,
  parameter int TIME_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write: epsilon_level
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [EPS_W-1:0]      cfg_data,
  // input items
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [0] show, [16:1] fade_ms, rest zero
  input  logic [CMD_W-1:0]      s_tuser,   // [1:0] command
  // result items
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // [15:0] level, [16] is_running,
                                           // [17] is_renderable, [18] wants_visible
);

  localparam int CMP_W = (LEVEL_BITS > EPS_W) ? LEVEL_BITS : EPS_W;
  localparam int DW    = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = {LEVEL_BITS{1'b1}};
  localparam logic [TIME_BITS-1:0]  TIME_MAX  = {TIME_BITS{1'b1}};

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_SQ     = 3'd3;
  localparam logic [2:0] ST_CUBE   = 3'd4;
  localparam logic [2:0] ST_MIX    = 3'd5;
  localparam logic [2:0] ST_RESULT = 3'd6;

  logic [2:0]            state;
  eps_t                  epsilon_level;
  logic [TIME_BITS-1:0]  elapsed_ms;
  logic [TIME_BITS-1:0]  total_ms;
  logic [LEVEL_BITS-1:0] start_level;
  logic [LEVEL_BITS-1:0] current_level;
  logic                  target_on;
  logic                  fading;

  // input fields
  cmd_t                  command;
  logic                  show;
  logic signed [FADE_W-1:0] fade_ms;

  logic                  in_acc;
  logic                  out_free;
  logic [DUR_W-1:0]      dur_ms;
  logic [DW-1:0]         dur_ext;
  logic [TIME_BITS-1:0]  dur_sat;
  logic [LEVEL_BITS-1:0] show_target;
  logic [LEVEL_BITS-1:0] target_level;
  logic [LEVEL_BITS-1:0] cmd_gap;
  logic [LEVEL_BITS-1:0] ease_gap;
  logic                  fade_runs;
  logic                  check_done;

  // serial units
  logic                       div_start;
  logic                       div_done;
  logic [FRAC_BITS-1:0]       ratio;
  logic                       mul_start;
  logic                       mul_done;
  logic [MUL_A_W-1:0]         mul_a;
  logic [MUL_B_W-1:0]         mul_b;
  logic [MUL_A_W+MUL_B_W-1:0] mul_prod;

  logic [LEVEL_BITS-1:0]  part;
  logic [LEVEL_BITS-1:0]  level_eased;
  logic [CMP_W-1:0]       cur_ext;
  logic                   renderable;

  assign command = s_tuser;
  assign show    = s_tdata[0];
  assign fade_ms = s_tdata[FADE_W:1];

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // negative durations count as zero; long ones saturate to the counter range
  assign dur_ms  = fade_ms[FADE_W-1] ? '0 : fade_ms[DUR_W-1:0];
  assign dur_ext = DW'(dur_ms);
  assign dur_sat = (dur_ext > DW'(TIME_MAX)) ? TIME_MAX : dur_ext[TIME_BITS-1:0];

  assign show_target  = show ? LEVEL_MAX : '0;
  assign target_level = target_on ? LEVEL_MAX : '0;
  assign cmd_gap      = show ? (LEVEL_MAX - current_level) : current_level;
  assign ease_gap     = target_on ? (LEVEL_MAX - start_level) : start_level;
  assign fade_runs    = (dur_ms != '0) && (CMP_W'(cmd_gap) > CMP_W'(epsilon_level));

  // fade over once elapsed reaches the duration
  assign check_done = (total_ms == '0) || (elapsed_ms >= total_ms);
  assign div_start  = (state == ST_CHECK) && !check_done;

  sfe_div #(
    .TIME_BITS(TIME_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (elapsed_ms),
    .den  (total_ms),
    .quo  (ratio),
    .done (div_done)
  );

  // operand select for the three multiplier passes; each starts as the
  // previous unit finishes
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state)
      ST_DIV: begin
        // t * t
        mul_start = div_done;
        mul_a     = MUL_A_W'(ratio);
        mul_b     = MUL_B_W'(ratio);
      end
      ST_SQ: begin
        // t^2 * (3 - 2t)
        mul_start = mul_done;
        mul_a     = mul_prod[MUL_A_W-1:0];
        mul_b     = S_COEF - MUL_B_W'({ratio, 1'b0});
      end
      ST_CUBE: begin
        // gap * s, s = previous product >> 32
        mul_start = mul_done;
        mul_a     = MUL_A_W'(ease_gap);
        mul_b     = mul_prod[MUL_A_W +: MUL_B_W];
      end
      default: ;
    endcase
  end

  sfe_mul #(
    .A_W(MUL_A_W),
    .B_W(MUL_B_W)
  ) u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_prod),
    .done (mul_done)
  );

  // round gap*s/2^16 to nearest, ties up in magnitude
  assign part = mul_prod[FRAC_BITS +: LEVEL_BITS]
              + LEVEL_BITS'(mul_prod[FRAC_BITS-1]);
  assign level_eased = target_on ? (start_level + part) : (start_level - part);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_tvalid      <= 1'b0;
      epsilon_level <= EPS_RESET;
      elapsed_ms    <= '0;
      total_ms      <= '0;
      start_level   <= '0;
      current_level <= '0;
      target_on     <= 1'b0;
      fading        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        epsilon_level <= cfg_data;
      end
      // result register: load when a result is ready, drop once taken
      if ((state == ST_RESULT) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            case (command)
              CMD_TICK: begin
                if (fading) begin
                  if (elapsed_ms != TIME_MAX) begin
                    elapsed_ms <= elapsed_ms + TIME_BITS'(1);
                  end
                  state <= ST_CHECK;
                end else begin
                  state <= ST_RESULT;
                end
              end
              CMD_FADE: begin
                total_ms    <= dur_sat;
                elapsed_ms  <= '0;
                start_level <= current_level;
                target_on   <= show;
                fading      <= fade_runs;
                if (!fade_runs) begin
                  current_level <= show_target;
                end
                state <= ST_RESULT;
              end
              CMD_HIDE: begin
                start_level   <= '0;
                current_level <= '0;
                target_on     <= 1'b0;
                fading        <= 1'b0;
                total_ms      <= '0;
                elapsed_ms    <= '0;
                state         <= ST_RESULT;
              end
              default: begin
                state <= ST_RESULT;
              end
            endcase
          end
        end
        ST_CHECK: begin
          if (check_done) begin
            current_level <= target_level;
            fading        <= 1'b0;
            state         <= ST_RESULT;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_SQ;
          end
        end
        ST_SQ: begin
          if (mul_done) begin
            state <= ST_CUBE;
          end
        end
        ST_CUBE: begin
          if (mul_done) begin
            state <= ST_MIX;
          end
        end
        ST_MIX: begin
          if (mul_done) begin
            current_level <= level_eased;
            state         <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result fields, taken from the state after the item
  assign cur_ext    = CMP_W'(current_level);
  assign renderable = fading || (cur_ext > CMP_W'(epsilon_level));

  always_ff @(posedge clk) begin
    if ((state == ST_RESULT) && out_free) begin
      m_tdata <= OUT_DATA_W'({target_on, renderable, fading, cur_ext[OUT_LEVEL_W-1:0]});
    end
  end

endmodule

// ----- rtl/sfe_checker.sv -----
// Port-level assertions for the smoothstep fade engine, bound to its top level.
// Uses sfe_pkg and smoothstep_fade_engine_macros.svh.
`timescale 1ns / 1ps
`include "smoothstep_fade_engine_macros.svh"

module sfe_checker import sfe_pkg::*; #(
  parameter int LEVEL_BITS = 16
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  localparam logic [31:0] FULL32 = (32'd1 << LEVEL_BITS) - 32'd1;
  localparam logic [OUT_LEVEL_W-1:0] FULL_LEVEL = FULL32[OUT_LEVEL_W-1:0];

  // a stalled result holds
  `SFE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // one item in flight: no second item right behind an accepted one
  `SFE_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

  // a running fade is always renderable
  `SFE_ASSERT_IMPL(a_run_render, m_tvalid && m_tdata[16], m_tdata[17])

  // with no fade running the level sits at the target
  `SFE_ASSERT_IMPL(a_idle_level, m_tvalid && !m_tdata[16],
    m_tdata[15:0] == (m_tdata[18] ? FULL_LEVEL : 16'h0000))

endmodule

bind smoothstep_fade_engine sfe_checker #(.LEVEL_BITS(LEVEL_BITS)) u_sfe_chk (.*);
